// ===== sv/srde_pkg.sv =====
package srde_pkg;

    localparam int RADIX_W   = 5;
    localparam int SYM_W     = 8;
    localparam int DIV_STEP  = 4;   // quotient bits resolved per divider cycle
    localparam int REG_IDX_W = 2;

    localparam logic [SYM_W-1:0]   SIGN_CHAR = 8'h2D;
    localparam logic [SYM_W-1:0]   PLUS_CHAR = 8'h2B;
    localparam logic [RADIX_W-1:0] MIN_RADIX = 5'd2;

    localparam logic [REG_IDX_W-1:0] REG_RADIX  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_SYM_LO = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_SYM_HI = 2'd2;

    localparam logic [RADIX_W-1:0] RADIX_RST  = 5'd10;
    localparam logic [63:0]        SYM_LO_RST = 64'h3736_3534_3332_3130;
    localparam logic [63:0]        SYM_HI_RST = 64'h0000_0000_0000_3938;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    // byte idx of the 16-byte alphabet, byte i in bits 8i+7..8i
    function automatic logic [SYM_W-1:0] symbol_at(input logic [63:0] sym_lo,
                                                   input logic [63:0] sym_hi,
                                                   input logic [3:0]  idx);
        logic [127:0] all_sym;
        all_sym = {sym_hi, sym_lo};
        return all_sym[{idx, 3'b000} +: SYM_W];
    endfunction

endpackage

// ===== sv/srde_alpha_chk.sv =====
module srde_alpha_chk #(
    parameter int MAX_RADIX = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [srde_pkg::RADIX_W-1:0] i_radix,
    input  logic [63:0]                 i_sym_lo,
    input  logic [63:0]                 i_sym_hi,
    output logic                        o_ok
);

    logic r_ok;
    logic w_bad;

    // radix range check, no NUL, '+' or '-' among the symbols in use, pairwise compare of them; result registered
    always_comb begin
        logic [srde_pkg::SYM_W-1:0] c;
        c     = '0;
        w_bad = (i_radix < srde_pkg::MIN_RADIX) ||
                (i_radix > srde_pkg::RADIX_W'(MAX_RADIX));
        for (int i = 0; i < 16; i++) begin
            if (srde_pkg::RADIX_W'(i) < i_radix) begin
                c = srde_pkg::symbol_at(i_sym_lo, i_sym_hi, 4'(i));
                if (c == '0 || c == srde_pkg::PLUS_CHAR || c == srde_pkg::SIGN_CHAR) begin
                    w_bad = 1'b1;
                end
                for (int j = i + 1; j < 16; j++) begin
                    if (srde_pkg::RADIX_W'(j) < i_radix &&
                        srde_pkg::symbol_at(i_sym_lo, i_sym_hi, 4'(j)) == c) begin
                        w_bad = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ok <= 1'b1;
        end else begin
            r_ok <= !w_bad;
        end
    end

    assign o_ok = r_ok;

endmodule

// ===== sv/srde_div.sv =====
module srde_div #(
    parameter int DIV_W = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [DIV_W-1:0]             i_dividend,
    input  logic [srde_pkg::RADIX_W-1:0] i_divisor,
    output logic                         o_done,
    output logic [DIV_W-1:0]             o_quotient,
    output logic [srde_pkg::RADIX_W-1:0] o_remainder
);

    localparam int NSTEPS = DIV_W / srde_pkg::DIV_STEP;
    localparam int CNT_W  = $clog2(NSTEPS);

    logic                         r_busy;
    logic                         r_done;
    logic [CNT_W-1:0]             r_cnt;
    logic [DIV_W-1:0]             r_quo;
    logic [srde_pkg::RADIX_W-1:0] r_rem;
    logic [DIV_W-1:0]             n_quo;
    logic [srde_pkg::RADIX_W-1:0] n_rem;

    // restoring division, DIV_STEP bits per cycle; dividend shifts out as quotient shifts in
    always_comb begin
        logic [srde_pkg::RADIX_W:0] wide;
        wide  = '0;
        n_quo = r_quo;
        n_rem = r_rem;
        for (int k = 0; k < srde_pkg::DIV_STEP; k++) begin
            wide  = {n_rem, n_quo[DIV_W-1]};
            n_quo = {n_quo[DIV_W-2:0], 1'b0};
            if (wide >= {1'b0, i_divisor}) begin
                wide     = wide - {1'b0, i_divisor};
                n_quo[0] = 1'b1;
            end
            n_rem = wide[srde_pkg::RADIX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NSTEPS - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

// ===== sv/signed_radix_digit_emitter.sv =====
// Signed radix digit emitter: converts a signed VALUE_BITS-bit integer into
// character bytes in the configured radix, from an alphabet of up to 16 symbols.
// Input channel (i_in_valid / o_in_ready, i_number): one request per number.
// Output channel (o_out_valid / i_out_ready, o_symbol, o_last): one request per
// character, most significant digit first, '-' ahead of a negative value, o_last
// set on the final character. An invalid alphabet gives no characters.
// Configuration is over the APB port: radix at 0x00, symbols_low at 0x08,
// symbols_high at 0x10; write only while no number is in flight.
// Timing: each digit is one pass through the shared divider, which resolves 4
// quotient bits a cycle. All digits of a number are converted, then emitted;
// the block takes one number at a time and o_in_ready stays low until its last
// character is loaded into the output register.
// A stalled receiver holds the output register and pauses emission; the next
// number may be accepted while the final character still waits.
// Reset is synchronous: alphabet returns to "0123456789", radix 10, no pending
// characters.
module signed_radix_digit_emitter #(
    parameter int MAX_RADIX  = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [4:0]                   paddr,
    input  logic [63:0]                  pwdata,
    output logic [63:0]                  prdata,
    output logic                         pready,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic signed [VALUE_BITS-1:0] i_number,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [7:0]                   o_symbol,
    output logic                         o_last
);

    localparam int DIV_W   = ((VALUE_BITS + srde_pkg::DIV_STEP - 1) / srde_pkg::DIV_STEP)
                             * srde_pkg::DIV_STEP;
    localparam int DIGIT_W = $clog2(MAX_RADIX);
    localparam int ND_W    = $clog2(VALUE_BITS + 1);

    // configuration
    logic [srde_pkg::RADIX_W-1:0]   r_radix;
    logic [63:0]                    r_sym_lo;
    logic [63:0]                    r_sym_hi;
    logic                           w_wr;
    logic [srde_pkg::REG_IDX_W-1:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[4:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix  <= srde_pkg::RADIX_RST;
            r_sym_lo <= srde_pkg::SYM_LO_RST;
            r_sym_hi <= srde_pkg::SYM_HI_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                srde_pkg::REG_RADIX:  r_radix  <= pwdata[srde_pkg::RADIX_W-1:0];
                srde_pkg::REG_SYM_LO: r_sym_lo <= pwdata;
                srde_pkg::REG_SYM_HI: r_sym_hi <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            srde_pkg::REG_RADIX:  prdata = 64'(r_radix);
            srde_pkg::REG_SYM_LO: prdata = r_sym_lo;
            srde_pkg::REG_SYM_HI: prdata = r_sym_hi;
            default:              prdata = '0;
        endcase
    end

    logic w_alpha_ok;

    srde_alpha_chk #(
        .MAX_RADIX (MAX_RADIX)
    ) u_alpha_chk (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_radix  (r_radix),
        .i_sym_lo (r_sym_lo),
        .i_sym_hi (r_sym_hi),
        .o_ok     (w_alpha_ok)
    );

    // sequencer
    srde_pkg::t_state             r_state, n_state;
    logic                         r_neg;
    logic [ND_W-1:0]              r_nd;
    logic [DIGIT_W-1:0]           r_stk [VALUE_BITS];
    logic                         r_out_valid;
    logic [7:0]                   r_symbol;
    logic                         r_last;

    logic                         w_accept;
    logic [VALUE_BITS-1:0]        w_num;
    logic [VALUE_BITS-1:0]        w_mag;
    logic                         w_div_start;
    logic [DIV_W-1:0]             w_dividend;
    logic                         w_div_done;
    logic [DIV_W-1:0]             w_quo;
    logic [srde_pkg::RADIX_W-1:0] w_rem;
    logic                         w_more;
    logic                         w_push;
    logic                         w_out_free;
    logic                         w_emit;
    logic                         w_pop;

    assign o_in_ready = (r_state == srde_pkg::S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_num      = i_number;
    // unsigned negate, so the most negative value keeps its full magnitude
    assign w_mag      = w_num[VALUE_BITS-1] ? (~w_num + 1'b1) : w_num;

    assign w_more = (w_quo != '0) && (r_nd < ND_W'(VALUE_BITS - 1));
    assign w_push = (r_state == srde_pkg::S_DIV) && w_div_done && w_alpha_ok;

    assign w_div_start = w_accept || (w_push && w_more);
    assign w_dividend  = w_accept ? DIV_W'(w_mag) : w_quo;

    srde_div #(
        .DIV_W (DIV_W)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_dividend  (w_dividend),
        .i_divisor   (r_radix),
        .o_done      (w_div_done),
        .o_quotient  (w_quo),
        .o_remainder (w_rem)
    );

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_emit     = (r_state == srde_pkg::S_EMIT) && w_out_free;
    assign w_pop      = w_emit && !r_neg;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            srde_pkg::S_IDLE: begin
                if (w_accept) n_state = srde_pkg::S_DIV;
            end
            srde_pkg::S_DIV: begin
                if (w_div_done) begin
                    if (!w_alpha_ok) n_state = srde_pkg::S_IDLE;
                    else if (!w_more) n_state = srde_pkg::S_EMIT;
                end
            end
            srde_pkg::S_EMIT: begin
                if (w_pop && r_nd == ND_W'(1)) n_state = srde_pkg::S_IDLE;
            end
            default: n_state = srde_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= srde_pkg::S_IDLE;
            r_neg       <= 1'b0;
            r_nd        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_neg <= w_num[VALUE_BITS-1];
                r_nd  <= '0;
            end else if (w_push) begin
                r_nd <= r_nd + 1'b1;
            end else if (w_pop) begin
                r_nd <= r_nd - 1'b1;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
                if (r_neg) r_neg <= 1'b0;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // digit stack: newest (most significant) at entry 0
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_stk[0] <= w_rem[DIGIT_W-1:0];
            for (int i = 1; i < VALUE_BITS; i++) begin
                r_stk[i] <= r_stk[i-1];
            end
        end else if (w_pop) begin
            for (int i = 0; i < VALUE_BITS - 1; i++) begin
                r_stk[i] <= r_stk[i+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            if (r_neg) begin
                r_symbol <= srde_pkg::SIGN_CHAR;
                r_last   <= 1'b0;
            end else begin
                r_symbol <= srde_pkg::symbol_at(r_sym_lo, r_sym_hi, 4'(r_stk[0]));
                r_last   <= (r_nd == ND_W'(1));
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_symbol    = r_symbol;
    assign o_last      = r_last;

    a_nd_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nd <= ND_W'(VALUE_BITS))
        else $error("digit count beyond value width");

    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == srde_pkg::S_EMIT) |-> (r_nd != '0))
        else $error("emitting with an empty digit stack");

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == srde_pkg::S_DIV))
        else $error("divider finished outside conversion");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == srde_pkg::S_DIV) && !o_in_ready)
        else $error("accepted request did not start conversion");

endmodule
